// ===== src/jss_pkg.sv =====
// Package for the job slot scheduler: table depth, entry record, codes
// and control structs. No dependencies.
package jss_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
  localparam logic [3:0] ERR_MAX = 4'd15;

  localparam logic [2:0] FN_ENQ    = 3'd0;
  localparam logic [2:0] FN_PICK   = 3'd1;
  localparam logic [2:0] FN_DERR   = 3'd2;
  localparam logic [2:0] FN_REL    = 3'd3;
  localparam logic [2:0] FN_CANCEL = 3'd4;
  localparam logic [2:0] FN_HALT   = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NONE    = 3'd1;
  localparam logic [2:0] ST_NOTFND  = 3'd2;
  localparam logic [2:0] ST_DUP     = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_SHUT    = 3'd5;

  localparam logic CFG_MAX_RUN = 1'b0;
  localparam logic CFG_RETRY   = 1'b1;

  typedef enum logic [2:0] {
    ES_QUEUED, ES_RUNNING, ES_PAUSED, ES_DONE, ES_FAILED
  } estate_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] job_id;
    logic [30:0] market;
    logic        kind;
    estate_t     state;
    logic        busy;
    logic [3:0]  errors;
  } entry_t;

  typedef enum logic [1:0] {CM_HOLD, CM_ROTATE, CM_PACK} chain_mode_t;

  typedef struct packed {
    chain_mode_t mode;
    logic        parity;
  } chain_ctl_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SCAN, PH_DECIDE, PH_APPLY, PH_PACK, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    AC_NONE, AC_ENQ, AC_PICK_RUN, AC_PICK_Q, AC_DERR, AC_REL, AC_CANCEL, AC_HALT
  } act_t;

endpackage

// ===== src/jss_cell.sv =====
// One table slot of the scheduler chain: rotates toward the head or
// swaps with a neighbor during compaction. Uses jss_pkg.
module jss_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  jss_pkg::chain_ctl_t ctl_i,
  input  logic               odd_pos_i,
  input  jss_pkg::entry_t    left_i,
  input  jss_pkg::entry_t    right_i,
  output jss_pkg::entry_t    ent_o
);
  import jss_pkg::*;

  entry_t ent_r, ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    case (ctl_i.mode)
      CM_ROTATE: ent_nxt = right_i;
      CM_PACK: begin
        if (odd_pos_i == ctl_i.parity) begin
          if (!ent_r.valid && right_i.valid) ent_nxt = right_i;
        end else begin
          if (!left_i.valid && ent_r.valid) ent_nxt = left_i;
        end
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent_o = ent_r;

endmodule

// ===== src/jss_chain.sv =====
// Row of jss_cell slots; head is slot 0, tail takes the controller's entry.
// Uses jss_pkg and jss_cell.
module jss_chain (
  input  logic               clk,
  input  logic               rst_n,
  input  jss_pkg::chain_ctl_t ctl_i,
  input  jss_pkg::entry_t    tail_i,
  output jss_pkg::entry_t    head_o
);
  import jss_pkg::*;

  localparam entry_t EDGE_ENT = '{valid: 1'b1, state: ES_QUEUED, default: '0};

  entry_t ent [TABLE_DEPTH];

  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    entry_t left_w, right_w;
    if (j == 0) begin : g_l0
      assign left_w = EDGE_ENT;
    end else begin : g_l
      assign left_w = ent[j-1];
    end
    if (j == TABLE_DEPTH - 1) begin : g_rl
      assign right_w = tail_i;
    end else begin : g_r
      assign right_w = ent[j+1];
    end
    jss_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_i     (ctl_i),
      .odd_pos_i (1'(j % 2)),
      .left_i    (left_w),
      .right_i   (right_w),
      .ent_o     (ent[j])
    );
  end

  assign head_o = ent[0];

endmodule

// ===== src/job_slot_scheduler_unit.sv =====
// Top level of the job slot scheduler: controller, counters, config and
// result register around the jss_chain slot row. Uses jss_pkg.
//
//  channel | signals                                   | dir
//  in      | in_valid in_stall in_func in_job_id ...   | item in
//  out     | out_valid out_stall out_status ...        | item out
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | register write
//
// An item runs from accept through a scan rotation of the slot ring, a
// decide state, an apply rotation, a result state and an idle state before
// the next accept; items with nothing to apply skip the apply rotation, and
// items that reap add odd/even compaction in the cells after it. A stalled
// result holds the result state.
// Reset clears slot valid bits, entry and busy counters, halt flag and config to 4 / 5.
// A result waits in the output register while the next item is accepted.
module job_slot_scheduler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_job_id,
  input  logic [30:0] in_market_id,
  input  logic        in_job_kind,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_picked_id,
  output logic        out_picked_kind,
  output logic        out_fail_flag,
  output logic [5:0]  out_entries_used,
  output logic [5:0]  out_busy_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);
  import jss_pkg::*;

  phase_t ph_r, ph_nxt;
  chain_ctl_t ctl;
  entry_t head, tail;

  logic [5:0] max_run_r;
  logic [3:0] retry_r;
  logic halted_r;
  logic [CNT_W-1:0] count_r, flight_r, alive_r, run_cnt_r;
  logic [IDX_W-1:0] pos_r;
  logic parity_r;
  logic pos_last;

  logic [2:0] func_r;
  logic [31:0] id_r;
  logic [30:0] mkt_r;
  logic kind_r;

  logic found_r, kkind_r, kinfl_r;
  logic [IDX_W-1:0] kidx_r, ridx_r, qidx_r, tgt_r;
  logic [3:0] kerr_r, err_new_r;
  logic dup_r, rfound_r, rkind_r, qfound_r, qkind_r;
  logic [31:0] rid_r, qid_r;

  act_t act_r, act_d;
  logic [2:0] status_r, status_d;
  logic [31:0] pid_r, pid_d;
  logic pkind_r, pkind_d, failed_r, failed_d, reap_r, reap_d;
  logic [IDX_W-1:0] tgt_d;
  logic [3:0] err_new_d;
  logic [CNT_W-1:0] flight_d;
  logic halt_d;

  logic out_valid_r;
  logic [2:0] o_status_r;
  logic [31:0] o_pid_r;
  logic o_pkind_r, o_failed_r;
  logic [5:0] o_used_r, o_flight_r;

  logic in_acc, out_load;
  entry_t mod_ent;
  logic pos_hit;

  jss_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl),
    .tail_i (tail),
    .head_o (head)
  );

  assign pos_last = (pos_r == IDX_W'(TABLE_DEPTH - 1));
  assign in_acc = in_valid && !in_stall;
  assign out_load = (ph_r == PH_DONE) && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    ph_nxt = ph_r;
    case (ph_r)
      PH_IDLE:   if (in_acc) ph_nxt = PH_SCAN;
      PH_SCAN:   if (pos_last) ph_nxt = PH_DECIDE;
      PH_DECIDE: ph_nxt = (act_d == AC_NONE) ? PH_DONE : PH_APPLY;
      PH_APPLY:  if (pos_last) ph_nxt = reap_r ? PH_PACK : PH_DONE;
      PH_PACK:   if (pos_last) ph_nxt = PH_DONE;
      PH_DONE:   if (out_load) ph_nxt = PH_IDLE;
      default:   ph_nxt = PH_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    ctl.mode = CM_HOLD;
    ctl.parity = parity_r;
    tail = head;
    case (ph_r)
      PH_IDLE: in_stall = 1'b0;
      PH_SCAN: ctl.mode = CM_ROTATE;
      PH_APPLY: begin
        ctl.mode = CM_ROTATE;
        tail = mod_ent;
      end
      PH_PACK: begin
        ctl.mode = CM_PACK;
        tail = '{valid: 1'b0, state: ES_QUEUED, default: '0};
      end
      default: ctl.mode = CM_HOLD;
    endcase
  end

  // apply pass: edit the head slot on its way to the tail
  always_comb begin
    mod_ent = head;
    pos_hit = (pos_r == tgt_r) && head.valid;
    case (act_r)
      AC_ENQ: begin
        if (CNT_W'(pos_r) == count_r) begin
          mod_ent.valid = 1'b1;
          mod_ent.job_id = id_r;
          mod_ent.market = mkt_r;
          mod_ent.kind = kind_r;
          mod_ent.state = ES_QUEUED;
          mod_ent.busy = 1'b0;
          mod_ent.errors = '0;
        end
      end
      AC_PICK_RUN: if (pos_hit) mod_ent.busy = 1'b1;
      AC_PICK_Q: begin
        if (pos_hit) begin
          mod_ent.state = ES_RUNNING;
          mod_ent.busy = 1'b1;
        end
      end
      AC_DERR: begin
        if (pos_hit) begin
          mod_ent.errors = err_new_r;
          if (failed_r) begin
            mod_ent.state = ES_FAILED;
            mod_ent.busy = 1'b0;
          end
        end
      end
      AC_REL: if (pos_hit) mod_ent.busy = 1'b0;
      AC_CANCEL: if (pos_hit) mod_ent.state = ES_FAILED;
      AC_HALT: begin
        if (head.valid && (head.state == ES_QUEUED || head.state == ES_RUNNING))
          mod_ent.state = ES_PAUSED;
      end
      default: mod_ent = head;
    endcase
    if (reap_r && mod_ent.valid && !mod_ent.busy &&
        (mod_ent.state == ES_DONE || mod_ent.state == ES_FAILED))
      mod_ent.valid = 1'b0;
  end

  // decision after the scan
  always_comb begin
    act_d = AC_NONE;
    status_d = ST_OK;
    pid_d = '0;
    pkind_d = 1'b0;
    failed_d = 1'b0;
    reap_d = 1'b0;
    tgt_d = kidx_r;
    err_new_d = (kerr_r == ERR_MAX) ? ERR_MAX : kerr_r + 4'd1;
    flight_d = flight_r;
    halt_d = halted_r;
    case (func_r)
      FN_ENQ: begin
        if (halted_r) status_d = ST_SHUT;
        else if (dup_r) status_d = ST_DUP;
        else if (count_r >= CNT_W'(TABLE_DEPTH)) status_d = ST_FULL;
        else begin
          act_d = AC_ENQ;
          pid_d = id_r;
          pkind_d = kind_r;
        end
      end
      FN_PICK: begin
        if (halted_r) status_d = ST_SHUT;
        else if (CMP_W'(run_cnt_r) < CMP_W'(max_run_r) && rfound_r) begin
          act_d = AC_PICK_RUN;
          tgt_d = ridx_r;
          pid_d = rid_r;
          pkind_d = rkind_r;
          flight_d = flight_r + 1'b1;
        end else if (CMP_W'(run_cnt_r) < CMP_W'(max_run_r) && qfound_r) begin
          act_d = AC_PICK_Q;
          tgt_d = qidx_r;
          pid_d = qid_r;
          pkind_d = qkind_r;
          flight_d = flight_r + 1'b1;
        end else status_d = ST_NONE;
      end
      FN_DERR, FN_REL, FN_CANCEL: begin
        if (!found_r) status_d = ST_NOTFND;
        else begin
          pid_d = id_r;
          pkind_d = kkind_r;
          if (func_r == FN_DERR) begin
            act_d = AC_DERR;
            failed_d = (err_new_d >= retry_r);
            reap_d = failed_d;
            if (failed_d && kinfl_r && flight_r != '0) flight_d = flight_r - 1'b1;
          end else if (func_r == FN_REL) begin
            act_d = AC_REL;
            reap_d = 1'b1;
            if (kinfl_r && flight_r != '0) flight_d = flight_r - 1'b1;
          end else begin
            act_d = AC_CANCEL;
            reap_d = 1'b1;
          end
        end
      end
      FN_HALT: begin
        act_d = AC_HALT;
        halt_d = 1'b1;
      end
      default: act_d = AC_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
      max_run_r <= 6'd4;
      retry_r <= 4'd5;
      halted_r <= 1'b0;
      count_r <= '0;
      flight_r <= '0;
      out_valid_r <= 1'b0;
      act_r <= AC_NONE;
      reap_r <= 1'b0;
      pos_r <= '0;
      parity_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAX_RUN) max_run_r <= cfg_data;
        else retry_r <= cfg_data[3:0];
      end
      if (ph_r == PH_SCAN || ph_r == PH_APPLY || ph_r == PH_PACK)
        pos_r <= pos_last ? '0 : pos_r + 1'b1;
      else
        pos_r <= '0;
      parity_r <= (ph_r == PH_PACK) ? !parity_r : 1'b0;
      if (ph_r == PH_DECIDE) begin
        act_r <= act_d;
        reap_r <= reap_d;
        flight_r <= flight_d;
        halted_r <= halt_d;
      end
      if (ph_r == PH_APPLY && pos_last) begin
        count_r <= alive_r + CNT_W'(mod_ent.valid);
      end
      if (ph_r == PH_DONE) act_r <= AC_NONE;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // item capture, scan gathering, result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      id_r <= in_job_id;
      mkt_r <= in_market_id;
      kind_r <= in_job_kind;
      found_r <= 1'b0;
      dup_r <= 1'b0;
      rfound_r <= 1'b0;
      qfound_r <= 1'b0;
      run_cnt_r <= '0;
    end
    if (ph_r == PH_SCAN && head.valid) begin
      if (!found_r && head.job_id == id_r) begin
        found_r <= 1'b1;
        kidx_r <= pos_r;
        kkind_r <= head.kind;
        kinfl_r <= head.busy;
        kerr_r <= head.errors;
      end
      if (!kind_r && head.market == mkt_r && !head.kind &&
          (head.state == ES_QUEUED || head.state == ES_RUNNING))
        dup_r <= 1'b1;
      if (head.state == ES_RUNNING && head.busy)
        run_cnt_r <= run_cnt_r + 1'b1;
      if (!rfound_r && head.state == ES_RUNNING && !head.busy) begin
        rfound_r <= 1'b1;
        ridx_r <= pos_r;
        rid_r <= head.job_id;
        rkind_r <= head.kind;
      end
      if (!qfound_r && head.state == ES_QUEUED) begin
        qfound_r <= 1'b1;
        qidx_r <= pos_r;
        qid_r <= head.job_id;
        qkind_r <= head.kind;
      end
    end
    if (ph_r == PH_DECIDE) begin
      status_r <= status_d;
      pid_r <= pid_d;
      pkind_r <= pkind_d;
      failed_r <= failed_d;
      tgt_r <= tgt_d;
      err_new_r <= err_new_d;
      alive_r <= '0;
    end
    if (ph_r == PH_APPLY && mod_ent.valid) alive_r <= alive_r + 1'b1;
    if (out_load) begin
      o_status_r <= status_r;
      o_pid_r <= pid_r;
      o_pkind_r <= pkind_r;
      o_failed_r <= failed_r;
      o_used_r <= 6'(count_r);
      o_flight_r <= 6'(flight_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = o_status_r;
  assign out_picked_id = o_pid_r;
  assign out_picked_kind = o_pkind_r;
  assign out_fail_flag = o_failed_r;
  assign out_entries_used = o_used_r;
  assign out_busy_total = o_flight_r;

endmodule
